>>> src/wsp_pkg.sv
`timescale 1ns / 1ps

package wsp_pkg;

	// drive clamp, symmetric about zero
	localparam int unsigned MAX_DRIVE = 10000;

	localparam int unsigned NUM_CFG_REGS = 8;
	localparam int unsigned CFG_IDX_W    = $clog2(NUM_CFG_REGS);
	localparam int unsigned CFG_DATA_W   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN         = 3'd0,
		CFG_INTEG_GAIN        = 3'd1,
		CFG_DRIVE_STEP_LIMIT  = 3'd2,
		CFG_OVERSHOOT_MARGIN  = 3'd3,
		CFG_OVERSPEED_DECAY   = 3'd4,
		CFG_STALL_DRIVE_LIMIT = 3'd5,
		CFG_STALL_TRIP_LEVEL  = 3'd6,
		CFG_COOLDOWN_TICKS    = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_REGULATE   = 3'd0,
		MODE_IDLE       = 3'd1,
		MODE_COOLDOWN   = 3'd2,
		MODE_OVERSPEED  = 3'd3,
		MODE_STALL_TRIP = 3'd4
	} mode_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [13:0] drive_step_limit;
		logic [10:0] overshoot_margin;
		logic [13:0] overspeed_decay;
		logic [13:0] stall_drive_limit;
		logic [15:0] stall_trip_level;
		logic [15:0] cooldown_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [14:0] last_drive;
		logic signed [12:0] previous_error;
		logic [15:0]        stall_cnt;
		logic [15:0]        cooldown_left;
	} state_t;

	localparam cfg_t CFG_RESET = '{
		prop_gain:         16'd256,
		integ_gain:        16'd32,
		drive_step_limit:  14'd500,
		overshoot_margin:  11'd20,
		overspeed_decay:   14'd200,
		stall_drive_limit: 14'd3000,
		stall_trip_level:  16'd50,
		cooldown_ticks:    16'd100
	};

	localparam state_t STATE_RESET = '0;

endpackage

>>> src/wsp_step.sv
`timescale 1ns / 1ps

// one control tick: next state and result from the current state and one sample
module wsp_step (
	input  logic signed [11:0] target_speed,
	input  logic signed [11:0] measured_speed,
	input  wsp_pkg::cfg_t      cfg,
	input  wsp_pkg::state_t    state,
	output wsp_pkg::state_t    state_next,
	output logic signed [14:0] drive,
	output wsp_pkg::mode_t     mode
);
	import wsp_pkg::*;

	localparam logic signed [24:0] MAX_W = 25'(MAX_DRIVE);

	logic signed [12:0] err;
	logic signed [13:0] err_diff;
	logic signed [31:0] p_term;
	logic signed [31:0] i_term;
	logic signed [31:0] pi_sum;
	logic signed [23:0] delta;
	logic signed [24:0] want;
	logic signed [15:0] clamped;
	logic signed [16:0] change;
	logic signed [16:0] step;
	logic signed [16:0] reg_drive;
	logic signed [14:0] new_drive;
	logic        [15:0] drive_mag;
	logic               near_standstill;
	logic        [15:0] stall_inc;
	logic signed [13:0] tgt_w;
	logic signed [13:0] meas_w;
	logic signed [13:0] margin_w;
	logic               fast;
	logic signed [15:0] ld_w;
	logic signed [15:0] decay_w;
	logic signed [15:0] decayed;

	// pi arithmetic
	always_comb begin
		err      = 13'(target_speed) - 13'(measured_speed);
		err_diff = 14'(err) - 14'(state.previous_error);
		p_term   = 32'($signed({1'b0, cfg.prop_gain})) * 32'(err_diff);
		i_term   = 32'($signed({1'b0, cfg.integ_gain})) * 32'(err);
		pi_sum   = p_term + i_term;
		// arithmetic shift floors, so nudge negative values with a remainder back toward zero
		delta    = 24'(pi_sum >>> 8);
		if (pi_sum[31] && (pi_sum[7:0] != 8'd0)) begin
			delta = delta + 24'sd1;
		end
		want = 25'(state.last_drive) + 25'(delta);
		if (want > MAX_W) begin
			clamped = 16'(MAX_W);
		end else if (want < -MAX_W) begin
			clamped = 16'(-MAX_W);
		end else begin
			clamped = want[15:0];
		end
		change = 17'(clamped) - 17'(state.last_drive);
		step   = $signed({3'b000, cfg.drive_step_limit});
		if (change > step) begin
			change = step;
		end else if (change < -step) begin
			change = -step;
		end
		reg_drive = 17'(state.last_drive) + change;
		new_drive = reg_drive[14:0];
		drive_mag = new_drive[14] ? 16'(-17'(new_drive)) : 16'(new_drive);
	end

	// overspeed test and decay
	always_comb begin
		tgt_w    = 14'(target_speed);
		meas_w   = 14'(measured_speed);
		margin_w = $signed({3'b000, cfg.overshoot_margin});
		if (target_speed > 12'sd0) begin
			fast = meas_w > (tgt_w + margin_w);
		end else begin
			fast = meas_w < (tgt_w - margin_w);
		end
		ld_w    = 16'(state.last_drive);
		decay_w = $signed({2'b00, cfg.overspeed_decay});
		if (ld_w > decay_w) begin
			decayed = ld_w - decay_w;
		end else if (ld_w < -decay_w) begin
			decayed = ld_w + decay_w;
		end else begin
			decayed = '0;
		end
	end

	always_comb begin
		near_standstill = (measured_speed >= -12'sd1) && (measured_speed <= 12'sd1);
		stall_inc = (state.stall_cnt == 16'hFFFF) ? state.stall_cnt
		                                          : state.stall_cnt + 16'd1;
	end

	// step priority: cooldown, zero target, overspeed, regulation
	always_comb begin
		state_next = state;
		mode       = MODE_REGULATE;
		if (state.cooldown_left != 16'd0) begin
			state_next.cooldown_left  = state.cooldown_left - 16'd1;
			state_next.stall_cnt      = '0;
			state_next.previous_error = '0;
			state_next.last_drive     = '0;
			mode                      = MODE_COOLDOWN;
		end else if (target_speed == 12'sd0) begin
			state_next.stall_cnt      = '0;
			state_next.previous_error = '0;
			state_next.last_drive     = '0;
			mode                      = MODE_IDLE;
		end else if (fast) begin
			state_next.stall_cnt  = '0;
			state_next.last_drive = decayed[14:0];
			mode                  = MODE_OVERSPEED;
		end else begin
			state_next.previous_error = err;
			state_next.last_drive     = new_drive;
			state_next.stall_cnt      = '0;
			if (near_standstill && (drive_mag > {2'b00, cfg.stall_drive_limit})) begin
				state_next.stall_cnt = stall_inc;
				if (stall_inc > cfg.stall_trip_level) begin
					state_next.cooldown_left  = cfg.cooldown_ticks;
					state_next.stall_cnt      = '0;
					state_next.previous_error = '0;
					state_next.last_drive     = '0;
					mode                      = MODE_STALL_TRIP;
				end
			end
		end
		drive = state_next.last_drive;
	end

endmodule

>>> src/wheel_speed_pi_with_stall_guard.sv
`timescale 1ns / 1ps

// Wheel speed PI controller with overspeed decay and stall guard. Each input
// transaction is one control tick (target and measured speed) and produces
// exactly one output transaction (signed drive and a mode code). A tick is
// captured in an input register, worked out in combinational logic (two
// parallel gain multipliers followed by clamp and rate limit), and written
// to the output register together with the controller state, so the result
// is valid once its tick is in the output register, and a new tick can be
// accepted every cycle while the output side keeps up. When the output
// register is full and not being taken, one further tick waits in the input
// register; in_ready drops only when both are full. Configuration writes take
// effect on the edge where cfg_wr_en is high and should only be issued while
// no tick is in flight. Reset restores all gains and limits to their defaults
// and clears the drive, error memory, stall count and cooldown.
module wheel_speed_pi_with_stall_guard (
	input  logic                                   clk,
	input  logic                                   arst_n,

	// configuration write port
	input  logic                                   cfg_wr_en,
	input  logic [wsp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [wsp_pkg::CFG_DATA_W-1:0]         cfg_data,

	// tick input
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [11:0]                     target_speed,
	input  logic signed [11:0]                     measured_speed,

	// result output
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [14:0]                     drive,
	output logic [2:0]                             mode
);
	import wsp_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_next;

	// input register stage
	logic               valid_s1;
	logic signed [11:0] target_s1;
	logic signed [11:0] measured_s1;

	// output register
	logic               out_valid_q;
	logic signed [14:0] drive_q;
	mode_t              mode_q;

	logic signed [14:0] step_drive;
	mode_t              step_mode;
	logic               advance;

	// a tick moves on when the output register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration registers, masked to their own widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PROP_GAIN:         cfg_q.prop_gain         <= cfg_data[15:0];
				CFG_INTEG_GAIN:        cfg_q.integ_gain        <= cfg_data[15:0];
				CFG_DRIVE_STEP_LIMIT:  cfg_q.drive_step_limit  <= cfg_data[13:0];
				CFG_OVERSHOOT_MARGIN:  cfg_q.overshoot_margin  <= cfg_data[10:0];
				CFG_OVERSPEED_DECAY:   cfg_q.overspeed_decay   <= cfg_data[13:0];
				CFG_STALL_DRIVE_LIMIT: cfg_q.stall_drive_limit <= cfg_data[13:0];
				CFG_STALL_TRIP_LEVEL:  cfg_q.stall_trip_level  <= cfg_data[15:0];
				CFG_COOLDOWN_TICKS:    cfg_q.cooldown_ticks    <= cfg_data[15:0];
				default:               cfg_q                   <= cfg_q;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			target_s1   <= target_speed;
			measured_s1 <= measured_speed;
		end
	end

	// per-tick arithmetic and decision
	wsp_step u_step (
		.target_speed   (target_s1),
		.measured_speed (measured_s1),
		.cfg            (cfg_q),
		.state          (state_q),
		.state_next     (state_next),
		.drive          (step_drive),
		.mode           (step_mode)
	);

	// controller state only moves when a tick is handed to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= step_drive;
			mode_q  <= step_mode;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign mode      = 3'(mode_q);

endmodule
